>>> rtl/core/lphs_pkg.sv
// lphs_pkg: shared types and constants for the linear probing hash set
// used by lphs_ctrl, lphs_out and linear_probe_hash_set
// no dependencies
package lphs_pkg;

  // table geometry (bucket count is a power of two, the probe index wraps)
  localparam int TABLE_SIZE = 1024;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int KEY_W      = 32;
  localparam int HOME_W     = 10;
  localparam int SLOT_W     = 10;
  localparam int CNT_W      = 11;
  localparam int ENTRY_W    = KEY_W + 1;

  localparam logic [KEY_W-1:0] EMPTY_KEY         = '1;
  localparam logic [CNT_W-1:0] FILL_LIMIT_RESET  = CNT_W'(768);
  localparam logic [IDX_W-1:0] LAST_IDX          = IDX_W'(TABLE_SIZE - 1);

  // request operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  typedef enum logic [2:0] {
    STS_INSERTED  = 3'd0,
    STS_PRESENT   = 3'd1,
    STS_DELETED   = 3'd2,
    STS_NOT_FOUND = 3'd3,
    STS_FOUND     = 3'd4,
    STS_FULL      = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [KEY_W-1:0]  key;
    logic [HOME_W-1:0] home_bucket;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  live_count;
    logic [CNT_W-1:0]  used_count;
  } resp_t;

endpackage

>>> rtl/core/lphs_ram.sv
// lphs_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module lphs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/lphs_ctrl.sv
// lphs_ctrl: probe sequencer, bucket store clearing pass, counts and fill limit
// depends on lphs_pkg; drives the bucket ram ports of lphs_ram
module lphs_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  // request channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  lphs_pkg::req_t                   in_data,
  // fill limit register write
  input  logic                             cfg_valid,
  input  logic [lphs_pkg::CNT_W-1:0]       cfg_data,
  // bucket ram
  output logic                             ram_we,
  output logic [lphs_pkg::IDX_W-1:0]       ram_waddr,
  output logic [lphs_pkg::ENTRY_W-1:0]     ram_wdata,
  output logic [lphs_pkg::IDX_W-1:0]       ram_raddr,
  input  logic [lphs_pkg::ENTRY_W-1:0]     ram_rdata,
  // result toward the output stage
  output logic                             res_valid,
  input  logic                             res_ready,
  output lphs_pkg::resp_t                  res_data
);

  lphs_pkg::state_t                 state_r, state_nxt;
  logic [lphs_pkg::IDX_W-1:0]       idx_r, idx_nxt;
  logic [lphs_pkg::IDX_W-1:0]       n_r, n_nxt;
  logic [lphs_pkg::IDX_W-1:0]       clr_idx_r, clr_idx_nxt;
  logic [1:0]                       op_r, op_nxt;
  logic [lphs_pkg::KEY_W-1:0]       key_r, key_nxt;
  logic [lphs_pkg::CNT_W-1:0]       live_r, live_nxt;
  logic [lphs_pkg::CNT_W-1:0]       used_r, used_nxt;
  logic [lphs_pkg::CNT_W-1:0]       fill_limit_r;
  lphs_pkg::resp_t                  res_r, res_nxt;

  logic [lphs_pkg::IDX_W-1:0]       idx_inc;
  logic [lphs_pkg::IDX_W-1:0]       home_idx;
  logic                             rd_used;
  logic [lphs_pkg::KEY_W-1:0]       rd_key;
  logic                             hit;
  logic                             last;
  logic                             skip;

  // unpack bucket entry: used flag on top, key below
  assign rd_used  = ram_rdata[lphs_pkg::KEY_W];
  assign rd_key   = ram_rdata[lphs_pkg::KEY_W-1:0];
  assign hit      = rd_used && (rd_key == key_r);
  assign last     = (n_r == lphs_pkg::LAST_IDX);
  assign idx_inc  = (idx_r == lphs_pkg::LAST_IDX) ? '0 : idx_r + 1'b1;
  assign home_idx = lphs_pkg::IDX_W'(in_data.home_bucket);

  // requests that finish without touching the chain
  assign skip = (key_r == lphs_pkg::EMPTY_KEY) || (op_r == lphs_pkg::OP_NONE) ||
                ((op_r == lphs_pkg::OP_INSERT) && (used_r > fill_limit_r));

  assign in_stall  = (state_r != lphs_pkg::S_IDLE);
  assign res_valid = (state_r == lphs_pkg::S_RESP);
  assign res_data  = res_r;

  // read address: home bucket on accept, next bucket while probing
  assign ram_raddr = (state_r == lphs_pkg::S_IDLE) ? home_idx : idx_inc;

  // next state, ram writes and result
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    n_nxt       = n_r;
    clr_idx_nxt = clr_idx_r;
    op_nxt      = op_r;
    key_nxt     = key_r;
    live_nxt    = live_r;
    used_nxt    = used_r;
    res_nxt     = res_r;
    ram_we      = 1'b0;
    ram_waddr   = idx_r;
    ram_wdata   = {1'b1, key_r};

    case (state_r)
      lphs_pkg::S_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_idx_r;
        ram_wdata   = {1'b0, lphs_pkg::EMPTY_KEY};
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == lphs_pkg::LAST_IDX) begin
          state_nxt = lphs_pkg::S_IDLE;
        end
      end

      lphs_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_data.req_type;
          key_nxt   = in_data.key;
          idx_nxt   = home_idx;
          n_nxt     = '0;
          state_nxt = lphs_pkg::S_PROBE;
        end
      end

      lphs_pkg::S_PROBE: begin
        res_nxt.status = lphs_pkg::STS_NOT_FOUND;
        res_nxt.slot   = '0;
        state_nxt      = lphs_pkg::S_RESP;
        if (skip) begin
          if ((key_r != lphs_pkg::EMPTY_KEY) && (op_r == lphs_pkg::OP_INSERT)) begin
            res_nxt.status = lphs_pkg::STS_FULL;
          end
        end else if (!rd_used) begin
          // never-used bucket ends the chain
          if (op_r == lphs_pkg::OP_INSERT) begin
            ram_we         = 1'b1;
            ram_wdata      = {1'b1, key_r};
            live_nxt       = live_r + 1'b1;
            used_nxt       = used_r + 1'b1;
            res_nxt.status = lphs_pkg::STS_INSERTED;
            res_nxt.slot   = lphs_pkg::SLOT_W'(idx_r);
          end
        end else if (hit) begin
          res_nxt.slot = lphs_pkg::SLOT_W'(idx_r);
          case (op_r)
            lphs_pkg::OP_INSERT: res_nxt.status = lphs_pkg::STS_PRESENT;
            lphs_pkg::OP_DELETE: begin
              // tombstone: bucket stays used, key becomes the sentinel
              ram_we         = 1'b1;
              ram_wdata      = {1'b1, lphs_pkg::EMPTY_KEY};
              if (live_r != '0) begin
                live_nxt = live_r - 1'b1;
              end
              res_nxt.status = lphs_pkg::STS_DELETED;
            end
            default: res_nxt.status = lphs_pkg::STS_FOUND;
          endcase
        end else if (last) begin
          // full pass without a match or a free bucket
          if (op_r == lphs_pkg::OP_INSERT) begin
            res_nxt.status = lphs_pkg::STS_FULL;
          end
        end else begin
          idx_nxt   = idx_inc;
          n_nxt     = n_r + 1'b1;
          state_nxt = lphs_pkg::S_PROBE;
        end
        res_nxt.live_count = live_nxt;
        res_nxt.used_count = used_nxt;
      end

      lphs_pkg::S_RESP: begin
        if (res_ready) begin
          state_nxt = lphs_pkg::S_IDLE;
        end
      end

      default: state_nxt = lphs_pkg::S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lphs_pkg::S_CLEAR;
      clr_idx_r    <= '0;
      live_r       <= '0;
      used_r       <= '0;
      fill_limit_r <= lphs_pkg::FILL_LIMIT_RESET;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      live_r    <= live_nxt;
      used_r    <= used_nxt;
      if (cfg_valid) begin
        fill_limit_r <= cfg_data;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    n_r   <= n_nxt;
    op_r  <= op_nxt;
    key_r <= key_nxt;
    res_r <= res_nxt;
  end

endmodule

>>> rtl/core/lphs_out.sv
// lphs_out: output register between the probe sequencer and the result channel
// depends on lphs_pkg
module lphs_out (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            res_valid,
  output logic            res_ready,
  input  lphs_pkg::resp_t res_data,
  output logic            out_valid,
  input  logic            out_stall,
  output lphs_pkg::resp_t out_data
);

  logic            out_valid_r, out_valid_nxt;
  lphs_pkg::resp_t out_data_r;

  // free when empty or when the held transaction leaves this cycle
  assign res_ready = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

endmodule

>>> rtl/core/linear_probe_hash_set.sv
// linear_probe_hash_set: top level of the linear probing hash set
// depends on lphs_pkg, lphs_ram, lphs_ctrl, lphs_out
//
// Usage:
//   in_*  : request transaction (operation, key, home bucket), valid/stall;
//           the block raises in_stall while it works on a request.
//   out_* : result transaction (status, slot, live and used counts),
//           valid/stall; a result is held in an output register until taken.
//   cfg_* : fill limit write, taken when cfg_valid and cfg_ready are high;
//           cfg_ready is always high, write only while the block is idle.
// Timing: one request at a time. A request probes k buckets (k >= 1, up
//   to one full pass of 1024), one bucket ram read per probe cycle, then
//   hands the result from the result state of lphs_ctrl to the output
//   register, which drives out_valid. Rejected requests (sentinel key,
//   unknown operation, insert over the fill limit) have k = 1.
// Reset: synchronous, active low. After reset a clearing pass writes every
//   bucket as never used, with in_stall high; fill limit writes are taken
//   during it. Counts clear and the fill limit returns to 768.
// Stall: a stalled result keeps its register; one more request can be
//   accepted and probed meanwhile, then the block waits for the register.
module linear_probe_hash_set (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  lphs_pkg::req_t               in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output lphs_pkg::resp_t              out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lphs_pkg::CNT_W-1:0]   cfg_data
);

  logic                            ram_we;
  logic [lphs_pkg::IDX_W-1:0]      ram_waddr;
  logic [lphs_pkg::ENTRY_W-1:0]    ram_wdata;
  logic [lphs_pkg::IDX_W-1:0]      ram_raddr;
  logic [lphs_pkg::ENTRY_W-1:0]    ram_rdata;
  logic                            res_valid;
  logic                            res_ready;
  lphs_pkg::resp_t                 res_data;

  assign cfg_ready = 1'b1;

  // bucket store: used flag and key per bucket
  lphs_ram #(
    .WIDTH (lphs_pkg::ENTRY_W),
    .DEPTH (lphs_pkg::TABLE_SIZE)
  ) u_bucket_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // probe sequencer
  lphs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  // result register
  lphs_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
